// ===== src/hba_pkg.sv =====
// Shared types and constants of the heap block allocator.
`default_nettype none

package hba_pkg;

  localparam int unsigned NEED_W = 17;  // rounded request size, up to 65536
  localparam int unsigned ALIGN  = 4;   // size granule and smallest split leftover

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2,
    FIT_NEXT  = 2'd3
  } fit_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_SET_ZERO, CMD_SET_MISS,
    CMD_SR_INIT, CMD_SR_RD, CMD_SR_EV, CMD_SR_END,
    CMD_SH_RD, CMD_SH_WR, CMD_SPLIT, CMD_MARK,
    CMD_OF_RD, CMD_OF_ACC, CMD_OF_DONE, CMD_APPEND,
    CMD_FR_INIT, CMD_FR_RD, CMD_FR_NEXT, CMD_FR_HIT,
    CMD_NX_RD, CMD_NX_MERGE, CMD_PV_MERGE,
    CMD_MG_RD, CMD_MG_WR, CMD_MG_END, CMD_PUBLISH
  } cmd_e;

  typedef struct packed {
    logic op_free;
    logic need_zero;
    logic addr_null;
    logic sr_more;
    logic sr_stop;
    logic found;
    logic split_ok;
    logic sh_more;
    logic of_more;
    logic fr_more;
    logic fr_match;
    logic fr_match_free;
    logic has_next;
    logic next_free;
    logic prev_merge;
    logic mg_more;
  } sts_t;

endpackage

`default_nettype wire

// ===== src/hba_if.sv =====
// Request and response channel interfaces of the heap block allocator.
`default_nettype none

interface hba_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] request_size;
  logic [15:0] block_address;

  modport source (output valid, opcode, request_size, block_address, input ready);
  modport sink   (input valid, opcode, request_size, block_address, output ready);
endinterface

interface hba_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_address;
  logic [1:0]  status;

  modport source (output valid, result_address, status, input ready);
  modport sink   (input valid, result_address, status, output ready);
endinterface

`default_nettype wire

// ===== src/hba_ctrl.sv =====
// Sequencer of the heap block allocator: walks the table operations step by step.
`default_nettype none

module hba_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  wire logic         rsp_ready_i,
  input  wire hba_pkg::sts_t sts_i,
  output hba_pkg::cmd_e     cmd_o
);
  import hba_pkg::*;

  typedef enum logic [19:0] {
    S_IDLE   = 20'h00001,
    S_DECODE = 20'h00002,
    S_SR_RD  = 20'h00004,
    S_SR_EV  = 20'h00008,
    S_SR_END = 20'h00010,
    S_SH_RD  = 20'h00020,
    S_SH_WR  = 20'h00040,
    S_SPLIT  = 20'h00080,
    S_MARK   = 20'h00100,
    S_OF_RD  = 20'h00200,
    S_OF_ACC = 20'h00400,
    S_APPEND = 20'h00800,
    S_FR_RD  = 20'h01000,
    S_FR_EV  = 20'h02000,
    S_NX_RD  = 20'h04000,
    S_NX_EV  = 20'h08000,
    S_PV     = 20'h10000,
    S_MG_RD  = 20'h20000,
    S_MG_WR  = 20'h40000,
    S_DONE   = 20'h80000
  } state_e;

  state_e state_q, state_d;
  logic   merge_prev_q, merge_prev_d;  // set while folding into the predecessor
  logic   rsp_valid_q, rsp_valid_d;

  always_comb begin
    state_d      = state_q;
    merge_prev_d = merge_prev_q;
    cmd_o        = CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.op_free) begin
          if (sts_i.addr_null) begin
            state_d = S_DONE;
          end else begin
            cmd_o   = CMD_FR_INIT;
            state_d = S_FR_RD;
          end
        end else if (sts_i.need_zero) begin
          cmd_o   = CMD_SET_ZERO;
          state_d = S_DONE;
        end else begin
          cmd_o   = CMD_SR_INIT;
          state_d = S_SR_RD;
        end
      end
      S_SR_RD: begin
        if (sts_i.sr_more) begin
          cmd_o   = CMD_SR_RD;
          state_d = S_SR_EV;
        end else begin
          state_d = S_SR_END;
        end
      end
      S_SR_EV: begin
        cmd_o   = CMD_SR_EV;
        state_d = sts_i.sr_stop ? S_SR_END : S_SR_RD;
      end
      S_SR_END: begin
        cmd_o = CMD_SR_END;
        if (!sts_i.found)        state_d = S_APPEND;
        else if (sts_i.split_ok) state_d = S_SH_RD;
        else                     state_d = S_MARK;
      end
      S_SH_RD: begin
        if (sts_i.sh_more) begin
          cmd_o   = CMD_SH_RD;
          state_d = S_SH_WR;
        end else begin
          state_d = S_SPLIT;
        end
      end
      S_SH_WR: begin
        cmd_o   = CMD_SH_WR;
        state_d = S_SH_RD;
      end
      S_SPLIT: begin
        cmd_o   = CMD_SPLIT;
        state_d = S_MARK;
      end
      S_MARK: begin
        cmd_o   = CMD_MARK;
        state_d = S_OF_RD;
      end
      S_OF_RD: begin
        if (sts_i.of_more) begin
          cmd_o   = CMD_OF_RD;
          state_d = S_OF_ACC;
        end else begin
          cmd_o   = CMD_OF_DONE;
          state_d = S_DONE;
        end
      end
      S_OF_ACC: begin
        cmd_o   = CMD_OF_ACC;
        state_d = S_OF_RD;
      end
      S_APPEND: begin
        cmd_o   = CMD_APPEND;
        state_d = S_DONE;
      end
      S_FR_RD: begin
        if (sts_i.fr_more) begin
          cmd_o   = CMD_FR_RD;
          state_d = S_FR_EV;
        end else begin
          cmd_o   = CMD_SET_MISS;
          state_d = S_DONE;
        end
      end
      S_FR_EV: begin
        if (!sts_i.fr_match) begin
          cmd_o   = CMD_FR_NEXT;
          state_d = S_FR_RD;
        end else if (sts_i.fr_match_free) begin
          cmd_o   = CMD_SET_MISS;
          state_d = S_DONE;
        end else begin
          cmd_o   = CMD_FR_HIT;
          state_d = S_NX_RD;
        end
      end
      S_NX_RD: begin
        if (sts_i.has_next) begin
          cmd_o   = CMD_NX_RD;
          state_d = S_NX_EV;
        end else begin
          state_d = S_PV;
        end
      end
      S_NX_EV: begin
        if (sts_i.next_free) begin
          cmd_o        = CMD_NX_MERGE;
          merge_prev_d = 1'b0;
          state_d      = S_MG_RD;
        end else begin
          state_d = S_PV;
        end
      end
      S_PV: begin
        if (sts_i.prev_merge) begin
          cmd_o        = CMD_PV_MERGE;
          merge_prev_d = 1'b1;
          state_d      = S_MG_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MG_RD: begin
        if (sts_i.mg_more) begin
          cmd_o   = CMD_MG_RD;
          state_d = S_MG_WR;
        end else begin
          cmd_o   = CMD_MG_END;
          state_d = merge_prev_q ? S_DONE : S_PV;
        end
      end
      S_MG_WR: begin
        cmd_o   = CMD_MG_WR;
        state_d = S_MG_RD;
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o   = CMD_PUBLISH;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o == CMD_PUBLISH) rsp_valid_d = 1'b1;
    else if (rsp_ready_i)     rsp_valid_d = 1'b0;
    else                      rsp_valid_d = rsp_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      merge_prev_q <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      merge_prev_q <= merge_prev_d;
      rsp_valid_q  <= rsp_valid_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;

endmodule

`default_nettype wire

// ===== src/hba_dp.sv =====
// Datapath of the heap block allocator: segment table memory, scan registers, arithmetic.
`default_nettype none

module hba_dp #(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned ARENA_BYTES  = 65536,
  parameter int unsigned HEADER_BYTES = 24
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_wdata_i,
  input  wire logic          req_opcode_i,
  input  wire logic [15:0]   req_size_i,
  input  wire logic [15:0]   req_addr_i,
  input  wire hba_pkg::cmd_e cmd_i,
  output hba_pkg::sts_t      sts_o,
  output logic [15:0]        rsp_addr_o,
  output logic [1:0]         rsp_status_o
);
  import hba_pkg::*;

  localparam int unsigned SW   = $clog2(ARENA_BYTES + 1);
  localparam int unsigned IW   = $clog2(MAX_SEGMENTS);
  localparam int unsigned CNTW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned CW   = ((SW > NEED_W) ? SW : NEED_W) + 2;
  localparam logic [CW-1:0]     HDR   = CW'(HEADER_BYTES);
  localparam logic [CW-1:0]     ARENA = CW'(ARENA_BYTES);
  localparam logic [CNTW-1:0]   MAXC  = CNTW'(MAX_SEGMENTS);
  localparam logic [NEED_W-1:0] RND   = NEED_W'(ALIGN - 1);

  // table memory: bit SW is the free mark, below it the size
  logic [SW:0]   mem_q [MAX_SEGMENTS];
  logic [SW:0]   rd_q;
  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [SW:0]   mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rd_q <= mem_q[mem_raddr];
  end

  // persistent state
  fit_e            pol_q, pol_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [SW-1:0]   top_q, top_d;
  logic [IW-1:0]   nfp_q, nfp_d;

  // per-item working registers
  logic              op_q, op_d;
  logic [NEED_W-1:0] need_q, need_d;
  logic [15:0]       addr_q, addr_d;
  logic [CNTW-1:0]   k_q, k_d, j_q, j_d, m_q, m_d;
  logic [IW-1:0]     idx_q, idx_d, f_q, f_d;
  logic              fnd_q, fnd_d, split_q, split_d, prev_free_q, prev_free_d;
  logic [SW-1:0]     fsize_q, fsize_d, off_q, off_d, cur_q, cur_d, prev_size_q, prev_size_d;
  logic [15:0]       res_addr_q, res_addr_d, rsp_addr_q, rsp_addr_d;
  status_e           res_st_q, res_st_d, rsp_st_q, rsp_st_d;

  logic              rd_free;
  logic [SW-1:0]     rd_size;
  logic [CW-1:0]     rd_sz_c, need_c, fsize_c, off_hdr, top_hdr, merged_c, pmerged_c;
  logic [CNTW-1:0]   f1, jm1, jp1;
  logic [NEED_W-1:0] need_sum;
  logic              fits, take, stop, app_ok;

  assign rd_free   = rd_q[SW];
  assign rd_size   = rd_q[SW-1:0];
  assign rd_sz_c   = CW'(rd_size);
  assign need_c    = CW'(need_q);
  assign fsize_c   = CW'(fsize_q);
  assign off_hdr   = CW'(off_q) + HDR;
  assign top_hdr   = CW'(top_q) + HDR;
  assign merged_c  = CW'(cur_q) + HDR + rd_sz_c;
  assign pmerged_c = CW'(prev_size_q) + HDR + CW'(cur_q);
  assign f1        = CNTW'(f_q) + CNTW'(1);
  assign jm1       = j_q - CNTW'(1);
  assign jp1       = j_q + CNTW'(1);
  assign need_sum  = NEED_W'(req_size_i) + RND;
  assign app_ok    = (cnt_q < MAXC) && (top_hdr + need_c <= ARENA);

  assign fits = rd_free && (rd_sz_c >= need_c);

  always_comb begin
    case (pol_q)
      FIT_BEST: begin
        take = fits && (!fnd_q || rd_sz_c < fsize_c);
        stop = take && (rd_sz_c == need_c);
      end
      FIT_WORST: begin
        take = fits && (!fnd_q || rd_sz_c > fsize_c);
        stop = 1'b0;
      end
      default: begin
        take = fits;
        stop = fits;
      end
    endcase
  end

  always_comb begin
    sts_o.op_free       = op_q;
    sts_o.need_zero     = (need_q == '0);
    sts_o.addr_null     = (addr_q == '0);
    sts_o.sr_more       = (k_q < cnt_q);
    sts_o.sr_stop       = stop || (k_q + CNTW'(1) >= cnt_q);
    sts_o.found         = fnd_q;
    sts_o.split_ok      = (fsize_c >= need_c + HDR + CW'(ALIGN)) && (cnt_q < MAXC);
    sts_o.sh_more       = (j_q > f1);
    sts_o.of_more       = (j_q < CNTW'(f_q));
    sts_o.fr_more       = (j_q < cnt_q);
    sts_o.fr_match      = (off_hdr == CW'(addr_q));
    sts_o.fr_match_free = rd_free;
    sts_o.has_next      = (f1 < cnt_q);
    sts_o.next_free     = rd_free;
    sts_o.prev_merge    = (f_q != '0) && prev_free_q;
    sts_o.mg_more       = (jp1 < cnt_q);
  end

  always_comb begin
    pol_d = pol_q; cnt_d = cnt_q; top_d = top_q; nfp_d = nfp_q;
    op_d = op_q; need_d = need_q; addr_d = addr_q;
    k_d = k_q; j_d = j_q; m_d = m_q; idx_d = idx_q; f_d = f_q;
    fnd_d = fnd_q; split_d = split_q; prev_free_d = prev_free_q;
    fsize_d = fsize_q; off_d = off_q; cur_d = cur_q; prev_size_d = prev_size_q;
    res_addr_d = res_addr_q; res_st_d = res_st_q;
    rsp_addr_d = rsp_addr_q; rsp_st_d = rsp_st_q;
    mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0; mem_raddr = '0;

    if (cfg_we_i) pol_d = fit_e'(cfg_wdata_i);

    case (cmd_i)
      CMD_LOAD: begin
        op_d       = req_opcode_i;
        need_d     = need_sum & ~RND;
        addr_d     = req_addr_i;
        res_addr_d = '0;
        res_st_d   = ST_OK;
      end
      CMD_SET_ZERO: res_st_d = ST_ZERO;
      CMD_SET_MISS: res_st_d = ST_MISS;
      CMD_SR_INIT: begin
        k_d   = '0;
        fnd_d = 1'b0;
        idx_d = (pol_q == FIT_NEXT && CNTW'(nfp_q) < cnt_q) ? nfp_q : '0;
      end
      CMD_SR_RD: mem_raddr = idx_q;
      CMD_SR_EV: begin
        if (take) begin
          fnd_d   = 1'b1;
          f_d     = idx_q;
          fsize_d = rd_size;
        end
        k_d   = k_q + CNTW'(1);
        idx_d = (CNTW'(idx_q) + CNTW'(1) == cnt_q) ? '0 : idx_q + IW'(1);
      end
      CMD_SR_END: begin
        if (pol_q == FIT_NEXT) nfp_d = fnd_q ? f_q : '0;
        split_d = sts_o.split_ok;
        j_d     = cnt_q;
      end
      CMD_SH_RD: mem_raddr = jm1[IW-1:0];
      CMD_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = j_q[IW-1:0];
        mem_wdata = rd_q;
        j_d       = jm1;
      end
      CMD_SPLIT: begin
        mem_we    = 1'b1;
        mem_waddr = f1[IW-1:0];
        mem_wdata = {1'b1, SW'(fsize_c - need_c - HDR)};
        cnt_d     = cnt_q + CNTW'(1);
        if (CNTW'(nfp_q) >= f1) nfp_d = nfp_q + IW'(1);
      end
      CMD_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = f_q;
        mem_wdata = {1'b0, split_q ? SW'(need_q) : fsize_q};
        j_d       = '0;
        off_d     = '0;
      end
      CMD_OF_RD: mem_raddr = j_q[IW-1:0];
      CMD_OF_ACC: begin
        off_d = SW'(off_hdr + rd_sz_c);
        j_d   = jp1;
      end
      CMD_OF_DONE: res_addr_d = off_hdr[15:0];
      CMD_APPEND: begin
        if (app_ok) begin
          mem_we     = 1'b1;
          mem_waddr  = cnt_q[IW-1:0];
          mem_wdata  = {1'b0, SW'(need_q)};
          cnt_d      = cnt_q + CNTW'(1);
          res_addr_d = top_hdr[15:0];
          top_d      = SW'(top_hdr + need_c);
        end else begin
          res_st_d = ST_FULL;
        end
      end
      CMD_FR_INIT: begin
        j_d         = '0;
        off_d       = '0;
        prev_free_d = 1'b0;
      end
      CMD_FR_RD: mem_raddr = j_q[IW-1:0];
      CMD_FR_NEXT: begin
        prev_size_d = rd_size;
        prev_free_d = rd_free;
        off_d       = SW'(off_hdr + rd_sz_c);
        j_d         = jp1;
      end
      CMD_FR_HIT: begin
        f_d       = j_q[IW-1:0];
        mem_we    = 1'b1;
        mem_waddr = j_q[IW-1:0];
        mem_wdata = {1'b1, rd_size};
        cur_d     = rd_size;
      end
      CMD_NX_RD: mem_raddr = f1[IW-1:0];
      CMD_NX_MERGE: begin
        mem_we    = 1'b1;
        mem_waddr = f_q;
        mem_wdata = {1'b1, SW'(merged_c)};
        cur_d     = SW'(merged_c);
        m_d       = f1;
        j_d       = f1;
      end
      CMD_PV_MERGE: begin
        mem_we    = 1'b1;
        mem_waddr = f_q - IW'(1);
        mem_wdata = {1'b1, SW'(pmerged_c)};
        m_d       = CNTW'(f_q);
        j_d       = CNTW'(f_q);
      end
      CMD_MG_RD: mem_raddr = jp1[IW-1:0];
      CMD_MG_WR: begin
        mem_we    = 1'b1;
        mem_waddr = j_q[IW-1:0];
        mem_wdata = rd_q;
        j_d       = jp1;
      end
      CMD_MG_END: begin
        cnt_d = cnt_q - CNTW'(1);
        if (CNTW'(nfp_q) >= m_q) nfp_d = nfp_q - IW'(1);
      end
      CMD_PUBLISH: begin
        rsp_addr_d = res_addr_q;
        rsp_st_d   = res_st_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_q <= FIT_FIRST;
      cnt_q <= '0;
      top_q <= '0;
      nfp_q <= '0;
    end else begin
      pol_q <= pol_d;
      cnt_q <= cnt_d;
      top_q <= top_d;
      nfp_q <= nfp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    need_q      <= need_d;
    addr_q      <= addr_d;
    k_q         <= k_d;
    j_q         <= j_d;
    m_q         <= m_d;
    idx_q       <= idx_d;
    f_q         <= f_d;
    fnd_q       <= fnd_d;
    split_q     <= split_d;
    prev_free_q <= prev_free_d;
    fsize_q     <= fsize_d;
    off_q       <= off_d;
    cur_q       <= cur_d;
    prev_size_q <= prev_size_d;
    res_addr_q  <= res_addr_d;
    res_st_q    <= res_st_d;
    rsp_addr_q  <= rsp_addr_d;
    rsp_st_q    <= rsp_st_d;
  end

  assign rsp_addr_o   = rsp_addr_q;
  assign rsp_status_o = rsp_st_q;

endmodule

`default_nettype wire

// ===== src/heap_block_allocator.sv =====
// Top level of the heap block allocator: sequencer, datapath and checks.
`default_nettype none

// Channel  Dir  Beat fields                                   Handshake
// req_i    in   opcode, request_size, block_address           valid / ready
// rsp_o    out  result_address, status                        valid / ready
// cfg      in   cfg_wdata_i (fit policy)                      cfg_we_i, no wait
//
// One request is in flight at a time; each table entry touched costs a
// registered memory read, then a use or write back. An allocate walks the
// live segments to search, those after the found one to shift for a split
// and those before it to sum the offset; a free scans up to the address
// and shifts the tail for each merge. No clearing pass is needed after reset.
// A finished response waits in its output register while the next request is
// taken; the sequencer stalls at the end only if that register is still full.

module heap_block_allocator #(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned ARENA_BYTES  = 65536,
  parameter int unsigned HEADER_BYTES = 24
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_wdata_i,
  hba_req_if.sink         req_i,
  hba_rsp_if.source       rsp_o
);
  import hba_pkg::*;

  cmd_e cmd;   // sequencer step for the datapath
  sts_t sts;   // datapath flags steering the sequencer

  hba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hba_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .ARENA_BYTES  (ARENA_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_opcode_i (req_i.opcode),
    .req_size_i   (req_i.request_size),
    .req_addr_i   (req_i.block_address),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .rsp_addr_o   (rsp_o.result_address),
    .rsp_status_o (rsp_o.status)
  );

  // A failed request never hands out an address.
  a_fail_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != ST_OK) |-> rsp_o.result_address == 16'd0)
    else $error("failed response carries an address");

  // Only one request in flight: ready drops right after a request beat.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while another is in work");

  // A new response is loaded only when the output register is free.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd == CMD_PUBLISH) |-> (!rsp_o.valid || rsp_o.ready))
    else $error("pending response overwritten");

endmodule

`default_nettype wire

// ===== tb/sv/hba_checker.sv =====
// Checker for the heap block allocator: predicts each response and compares it.
`timescale 1ns / 1ps

module hba_checker #(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned ARENA_BYTES  = 65536,
  parameter int unsigned HEADER_BYTES = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  hba_req_if         req,
  hba_rsp_if         rsp,
  output int         fail_count_o,
  output int         pending_o
);
  import hba_pkg::*;

  typedef struct packed {
    logic [15:0] addr;
    status_e     status;
  } hba_result_t;

  // Shadow of the segment table
  logic [16:0] seg_size [MAX_SEGMENTS];
  logic        seg_free [MAX_SEGMENTS];
  int unsigned seg_cnt;
  int unsigned heap_top;
  int unsigned nfit_pos;
  fit_e        policy;

  hba_result_t expected_rsp [$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_rsp.size();

  function automatic int unsigned seg_offset(int unsigned idx);
    int unsigned off;
    off = 0;
    for (int unsigned i = 0; i < idx && i < seg_cnt; i++) off += HEADER_BYTES + seg_size[i];
    return off;
  endfunction

  function automatic void insert_slot(int unsigned idx);
    for (int unsigned i = seg_cnt; i > idx; i--) begin
      seg_size[i] = seg_size[i-1];
      seg_free[i] = seg_free[i-1];
    end
    seg_cnt++;
    if (nfit_pos >= idx) nfit_pos++;
  endfunction

  // Fold entry idx into its predecessor and close the gap
  function automatic void fold_down(int unsigned idx);
    seg_size[idx-1] = seg_size[idx-1] + HEADER_BYTES + seg_size[idx];
    for (int unsigned i = idx; i + 1 < seg_cnt; i++) begin
      seg_size[i] = seg_size[i+1];
      seg_free[i] = seg_free[i+1];
    end
    seg_cnt--;
    if (nfit_pos >= idx) nfit_pos--;
  endfunction

  function automatic bit seg_fits(int unsigned i, int unsigned need);
    return seg_free[i] && seg_size[i] >= need;
  endfunction

  function automatic int pick_segment(int unsigned need);
    int          hit;
    int unsigned i, start;
    hit = -1;
    case (policy)
      FIT_FIRST: begin
        for (i = 0; i < seg_cnt; i++)
          if (seg_fits(i, need)) begin
            hit = i;
            break;
          end
      end
      FIT_BEST: begin
        for (i = 0; i < seg_cnt; i++)
          if (seg_fits(i, need) && (hit < 0 || seg_size[i] < seg_size[hit])) begin
            hit = i;
            if (seg_size[i] == need) break;
          end
      end
      FIT_WORST: begin
        for (i = 0; i < seg_cnt; i++)
          if (seg_fits(i, need) && (hit < 0 || seg_size[i] > seg_size[hit])) hit = i;
      end
      default: begin
        start = (nfit_pos < seg_cnt) ? nfit_pos : 0;
        for (int unsigned k = 0; k < seg_cnt; k++) begin
          i = start + k;
          if (i >= seg_cnt) i -= seg_cnt;
          if (seg_fits(i, need)) begin
            hit = i;
            break;
          end
        end
        nfit_pos = (hit < 0) ? 0 : hit;
      end
    endcase
    return hit;
  endfunction

  function automatic hba_result_t serve_request(logic op, logic [15:0] size, logic [15:0] addr);
    hba_result_t r;
    int unsigned need, idx, off;
    int          f, hit;
    r.addr = '0;
    r.status = ST_OK;
    if (op == OP_ALLOC) begin
      need = (int'(size) + 3) & ~32'd3;
      if (need == 0) begin
        r.status = ST_ZERO;
      end else begin
        f = pick_segment(need);
        if (f >= 0) begin
          idx = f;
          if (seg_size[idx] >= need + HEADER_BYTES + ALIGN && seg_cnt < MAX_SEGMENTS) begin
            off = seg_size[idx] - need - HEADER_BYTES;
            insert_slot(idx + 1);
            seg_size[idx+1] = off;
            seg_free[idx+1] = 1'b1;
            seg_size[idx] = need;
          end
          seg_free[idx] = 1'b0;
          r.addr = 16'(seg_offset(idx) + HEADER_BYTES);
        end else if (seg_cnt >= MAX_SEGMENTS || heap_top + HEADER_BYTES + need > ARENA_BYTES) begin
          r.status = ST_FULL;
        end else begin
          seg_size[seg_cnt] = need;
          seg_free[seg_cnt] = 1'b0;
          seg_cnt++;
          r.addr = 16'(heap_top + HEADER_BYTES);
          heap_top += HEADER_BYTES + need;
        end
      end
    end else if (addr != 0) begin
      off = 0;
      hit = -1;
      for (int unsigned i = 0; i < seg_cnt; i++) begin
        if (off + HEADER_BYTES == addr) begin
          hit = i;
          break;
        end
        off += HEADER_BYTES + seg_size[i];
      end
      if (hit < 0 || seg_free[hit]) begin
        r.status = ST_MISS;
      end else begin
        idx = hit;
        seg_free[idx] = 1'b1;
        if (idx + 1 < seg_cnt && seg_free[idx+1]) fold_down(idx + 1);
        if (idx > 0 && seg_free[idx-1]) fold_down(idx);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    hba_result_t want;
    if (!rst_ni) begin
      seg_cnt  = 0;
      heap_top = 0;
      nfit_pos = 0;
      policy   = FIT_FIRST;
      fails    = 0;
      expected_rsp.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("unexpected response, address", rsp.result_address, -1);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.result_address !== want.addr)
            report_mismatch("result_address", rsp.result_address, want.addr);
          if (rsp.status !== want.status)
            report_mismatch("status", rsp.status, want.status);
        end
      end
      if (req.valid && req.ready)
        expected_rsp.push_back(serve_request(req.opcode, req.request_size, req.block_address));
      if (cfg_we_i) policy = fit_e'(cfg_wdata_i);
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top of the heap block allocator: stimulus, pressure and verdict.
`timescale 1ns / 1ps

module tb;
  import hba_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned DRAIN_WAIT  = 600;   // idle wait once every response is back
  localparam int unsigned PHASE_ITEMS = 215;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [1:0] cfg_wdata;
  int         fail_count;
  int         pending;
  int         long_hold;
  bit         quiet;
  int unsigned cycles;

  hba_req_if req ();
  hba_rsp_if rsp ();

  // Data addresses believed live, and ones already handed back
  logic [15:0] live_addr [$];
  logic [15:0] freed_addr [$];

  heap_block_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req),
    .rsp_o       (rsp)
  );

  hba_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .req          (req),
    .rsp          (rsp),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: end the run if the block hangs
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Record every address the block hands out so later frees hit real blocks
  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready && rsp.status == ST_OK && rsp.result_address != 0)
      live_addr.push_back(rsp.result_address);
  end

  // Response side: random stall bursts, one long hold-off on request
  initial begin
    int idle_left;
    idle_left = 0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold > 0) begin
        long_hold--;
        rsp.ready <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        rsp.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        idle_left = $urandom_range(1, 11) - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Offer one beat, hold until accepted; called at a falling edge, returns at one
  task automatic send_beat(logic op, logic [15:0] size, logic [15:0] addr);
    int i;
    if (op == OP_FREE) begin
      for (i = 0; i < live_addr.size(); i++)
        if (live_addr[i] == addr) begin
          live_addr.delete(i);
          freed_addr.push_back(addr);
          break;
        end
    end
    req.valid         <= 1'b1;
    req.opcode        <= op;
    req.request_size  <= size;
    req.block_address <= addr;
    do @(posedge clk_i); while (!req.ready);
    @(negedge clk_i);
  endtask

  task automatic sender_gap();
    int n;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 11);
      req.valid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // Drop valid and wait until the block has answered everything and gone quiet
  task automatic drain();
    req.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic set_policy(fit_e p);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= p;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    @(negedge clk_i);
  endtask

  // One random beat: mostly sensible alloc/free traffic, some noise
  task automatic random_beat();
    int          pick, k;
    logic [15:0] sz, ad;
    pick = $urandom_range(0, 99);
    sz   = 16'($urandom_range(0, 65535));
    ad   = 16'($urandom_range(0, 65535));
    if (pick < 40 && live_addr.size() > 0) begin
      k = $urandom_range(0, live_addr.size() - 1);
      send_beat(OP_FREE, sz, live_addr[k]);
    end else if (pick < 85) begin
      // small sizes fill the table; a few big ones hit the arena limit
      if ($urandom_range(0, 39) == 0) sz = 16'($urandom_range(1000, 20000));
      else sz = 16'($urandom_range(1, 300));
      send_beat(OP_ALLOC, sz, ad);
    end else if (pick < 89) begin
      send_beat(OP_ALLOC, 16'd0, ad);
    end else if (pick < 93 && freed_addr.size() > 0) begin
      // double free, or a free of a stale address
      k = $urandom_range(0, freed_addr.size() - 1);
      send_beat(OP_FREE, sz, freed_addr[k]);
    end else if (pick < 97) begin
      send_beat(OP_FREE, sz, ad);
    end else begin
      send_beat(OP_ALLOC, sz, ad);
    end
  endtask

  initial begin
    fit_e order [8];
    order = '{FIT_FIRST, FIT_BEST, FIT_WORST, FIT_NEXT, FIT_NEXT, FIT_BEST, FIT_WORST,
              FIT_FIRST};
    cycles            = 0;
    long_hold         = 0;
    quiet             = 1'b0;
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = FIT_FIRST;
    req.valid         = 1'b0;
    req.opcode        = OP_ALLOC;
    req.request_size  = '0;
    req.block_address = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: zero size, arena full, null/unknown/double free, exact reuse,
    // fill to the last byte, merge on both sides, split of a big segment
    set_policy(FIT_FIRST);
    send_beat(OP_ALLOC, 16'd0,     16'hFFFF);
    send_beat(OP_ALLOC, 16'hFFFF,  16'h0000);
    send_beat(OP_FREE,  16'hFFFF,  16'd0);
    send_beat(OP_FREE,  16'd0,     16'd24);
    send_beat(OP_ALLOC, 16'd1,     16'd0);
    send_beat(OP_ALLOC, 16'd8,     16'd0);
    send_beat(OP_FREE,  16'd0,     16'd24);
    send_beat(OP_FREE,  16'd0,     16'd24);
    send_beat(OP_ALLOC, 16'd4,     16'd0);
    send_beat(OP_ALLOC, 16'hFFFF,  16'd0);
    send_beat(OP_FREE,  16'd0,     16'd52);
    send_beat(OP_FREE,  16'd0,     16'd24);
    send_beat(OP_ALLOC, 16'd65452, 16'd0);
    send_beat(OP_ALLOC, 16'd1,     16'd0);
    send_beat(OP_FREE,  16'd0,     16'd84);
    send_beat(OP_FREE,  16'd0,     16'hFFFF);
    send_beat(OP_ALLOC, 16'd100,   16'd0);
    send_beat(OP_ALLOC, 16'd3,     16'd0);
    send_beat(OP_FREE,  16'd0,     16'd24);
    send_beat(OP_ALLOC, 16'd2,     16'd0);
    send_beat(OP_FREE,  16'd0,     16'h8000);

    for (int p = 0; p < 8; p++) begin
      set_policy(order[p]);
      if (p == 7) quiet = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold responses long enough that the block stalls its input
        if (p == 2 && n == 20) long_hold = 3000;
        // pause the sender until every result is back
        if (p == 4 && n == 100) begin
          req.valid <= 1'b0;
          @(negedge clk_i);
          while (pending != 0) @(negedge clk_i);
        end
        sender_gap();
        random_beat();
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
